/* src/ofs_pkg.sv */
package ofs_pkg;

	localparam int COLUMNS     = 128;
	localparam int ROWS        = 64;
	localparam int STORE_BYTES = 1024;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int POS_W  = $clog2(STORE_BYTES + 2);
	localparam int IDX_W  = 12;
	localparam int CMD_LEN = 8;

	localparam logic [7:0] DEV_ADDR_RESET = 8'd120;
	localparam logic [7:0] CTRL_CMD       = 8'h00;
	localparam logic [7:0] CTRL_DATA      = 8'h40;
	localparam logic [7:0] CMD_COL_ADDR   = 8'h21;
	localparam logic [7:0] CMD_PAGE_ADDR  = 8'h22;
	localparam logic [7:0] AREA_START     = 8'h00;
	localparam logic [7:0] COL_END        = 8'((COLUMNS - 1) % 256);
	localparam logic [7:0] PAGE_END       = 8'((((ROWS + 7) / 8) - 1) % 256);

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_START = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic       pixel_on;
	} ofs_item_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] bus_byte;
		logic       start_before;
		logic       stop_after;
		logic       busy_res;
		logic       update_done;
	} ofs_result_t;

	// bytes of the command transaction, by position
	function automatic logic [7:0] cmd_byte(input logic [2:0] pos, input logic [7:0] dev);
		logic [7:0] b;
		unique case (pos)
			3'd0: b = dev;
			3'd1: b = CTRL_CMD;
			3'd2: b = CMD_COL_ADDR;
			3'd3: b = AREA_START;
			3'd4: b = COL_END;
			3'd5: b = CMD_PAGE_ADDR;
			3'd6: b = AREA_START;
			default: b = PAGE_END;
		endcase
		return b;
	endfunction

endpackage

/* src/ofs_if.sv */
interface ofs_item_if import ofs_pkg::*; ();
	logic      valid;
	logic      ready;
	ofs_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ofs_result_if import ofs_pkg::*; ();
	logic        valid;
	logic        ready;
	ofs_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/oled_framebuffer_bus_streamer.sv */
// Channel  Dir  Beat payload                                  Handshake
// -------  ---  --------------------------------------------  ----------------
// item     in   mode, pixel_x, pixel_y, pixel_on              valid/ready
// result   out  byte_valid, bus_byte, start/stop marks,       valid/ready
//               busy_res, update_done
// cfg      in   cfg_wdata = device_address                    cfg_we, no wait
//
// Every item beat yields exactly one result beat, and item.ready stays low
// from acceptance until that result beat is taken. An in-range pixel write
// while no transfer runs does its read and write back on the single
// framebuffer RAM before the next item is taken; a data-phase tick that
// carries a store byte first passes through a fetch state (registered RAM
// read). A clear beat while no transfer runs returns its result and then
// sweeps all STORE_BYTES bytes of the store, one byte per cycle, with
// item.ready low. After arst_n the same sweep runs before the first item
// is taken. A stalled result holds item.ready low until it is taken.
module oled_framebuffer_bus_streamer import ofs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	ofs_item_if.sink           item,
	ofs_result_if.source       result
);

	// sequencer around the one framebuffer RAM
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RMW   = 4'b0100,
		ST_FETCH = 4'b1000
	} state_t;

	// bus transfer phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_CMD  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [7:0]        dev_addr_q;
	logic              out_valid_q;
	ofs_result_t       out_q, out_d;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [7:0]        mask_q;
	logic              pix_on_q;

	logic              accept;
	logic              busy;
	logic              in_range;
	logic [IDX_W-1:0]  pix_idx;
	logic [ADDR_W-1:0] data_idx;
	logic              out_load;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign item.ready   = (state_q == ST_IDLE) && !out_valid_q;
	assign accept       = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign busy = (phase_q != PH_IDLE);

	// page-ordered address: (y/8)*COLUMNS + x
	assign pix_idx  = IDX_W'(item.data.pixel_y[7:3]) * IDX_W'(COLUMNS)
		+ IDX_W'(item.data.pixel_x);
	assign in_range = ({1'b0, item.data.pixel_x} < 9'(COLUMNS))
		&& ({1'b0, item.data.pixel_y} < 9'(ROWS))
		&& (pix_idx < IDX_W'(STORE_BYTES));
	// data bytes follow the address and control byte
	assign data_idx = ADDR_W'(pos_q - POS_W'(2));

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		pos_d    = pos_q;
		out_d    = '0;
		out_load = 1'b0;
		if (accept) begin
			out_load       = 1'b1;
			out_d.busy_res = busy;
			unique case (item.data.mode)
				MODE_PIXEL: begin
					if (!busy && in_range) begin
						state_d = ST_RMW;
					end
				end
				MODE_CLEAR: begin
					if (!busy) begin
						state_d = ST_CLEAR;
					end
				end
				MODE_START: begin
					out_d.busy_res = 1'b1;
					if (!busy) begin
						phase_d = PH_CMD;
						pos_d   = '0;
					end
				end
				MODE_TICK: begin
					unique case (phase_q)
						PH_CMD: begin
							out_d.byte_valid   = 1'b1;
							out_d.bus_byte     = cmd_byte(pos_q[2:0], dev_addr_q);
							out_d.start_before = (pos_q == '0);
							out_d.busy_res     = 1'b1;
							if (pos_q >= POS_W'(CMD_LEN - 1)) begin
								out_d.stop_after = 1'b1;
								phase_d          = PH_DATA;
								pos_d            = '0;
							end else begin
								pos_d = pos_q + POS_W'(1);
							end
						end
						PH_DATA: begin
							out_d.byte_valid = 1'b1;
							out_d.busy_res   = 1'b1;
							if (pos_q == '0) begin
								out_d.bus_byte     = dev_addr_q;
								out_d.start_before = 1'b1;
							end else if (pos_q == POS_W'(1)) begin
								out_d.bus_byte = CTRL_DATA;
							end else begin
								// byte arrives from the RAM next cycle
								state_d  = ST_FETCH;
								out_load = 1'b0;
							end
							if (pos_q >= POS_W'(STORE_BYTES + 1)) begin
								out_d.stop_after  = 1'b1;
								out_d.update_done = 1'b1;
								out_d.busy_res    = 1'b0;
								phase_d           = PH_IDLE;
								pos_d             = '0;
							end else begin
								pos_d = pos_q + POS_W'(1);
							end
						end
						default: begin
							phase_d = PH_IDLE;
							pos_d   = '0;
						end
					endcase
				end
				default: ;
			endcase
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_d = ST_IDLE;
					end
				end
				ST_RMW:   state_d = ST_IDLE;
				ST_FETCH: state_d = ST_IDLE;
				default:  ;
			endcase
		end
	end

	// framebuffer port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_RMW) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_q;
			ram_wdata = pix_on_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
		end
		ram_raddr = (item.data.mode == MODE_PIXEL) ? ADDR_W'(pix_idx) : data_idx;
	end

	ofs_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			clr_addr_q  <= '0;
			dev_addr_q  <= DEV_ADDR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			if (cfg_we) begin
				dev_addr_q <= cfg_wdata;
			end
			if (accept && item.data.mode == MODE_CLEAR) begin
				clr_addr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (out_load || state_q == ST_FETCH) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q     <= out_d;
			wr_addr_q <= ADDR_W'(pix_idx);
			mask_q    <= 8'b1 << item.data.pixel_y[2:0];
			pix_on_q  <= item.data.pixel_on;
		end else if (state_q == ST_FETCH) begin
			out_q.bus_byte <= ram_rdata;
		end
	end

endmodule

/* src/ofs_ram.sv */
module ofs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
